FILE: hdl/spq_pkg.sv
// shared constants, codes and types of the sorted priority queue
package spq_pkg;

  // queue size and derived widths
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // field widths of the command and result words
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 9;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // one held entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

FILE: hdl/spq_in_if.sv
// command channel of the sorted priority queue
interface spq_in_if import spq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0]  item_priority;
  logic [POS_W-1:0]          position;

  modport source (output valid, kind, item_value, item_priority, position, input ready);
  modport sink (input valid, kind, item_value, item_priority, position, output ready);
  modport monitor (input valid, ready, kind, item_value, item_priority, position);
endinterface

FILE: hdl/spq_out_if.sv
// result channel of the sorted priority queue
interface spq_out_if import spq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] taken_value;
  logic signed [PRIO_W-1:0]  taken_priority;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, status, taken_value, taken_priority, occupancy, input ready);
  modport sink (input valid, status, taken_value, taken_priority, occupancy, output ready);
  modport monitor (input valid, ready, status, taken_value, taken_priority, occupancy);
endinterface

FILE: hdl/spq_ram.sv
// single-port-write, single-port-read entry memory with registered read data
module spq_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_priority_queue.sv
// top level of the sorted priority queue
// Holds up to DEPTH (value, priority) entries in ascending priority order in
// one entry memory, with equal priorities kept in arrival order. Each command
// word gives exactly one result word. A small sequencer walks the memory one
// entry at a time through its single write and registered read port. An
// insert moves each entry of higher priority than the new one up one place,
// and a remove or delete moves each entry behind the taken one down one place.
// One command is worked at a time; the next command word is taken once the
// result has been handed to the result register, even while that result
// still waits to be taken.
module sorted_priority_queue import spq_pkg::*; (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   cmd,
  spq_out_if.source rsp
);

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_PUT = 9'b000001000,
    S_DEL_RD  = 9'b000010000,
    S_DEL_CAP = 9'b000100000,
    S_SH_RD   = 9'b001000000,
    S_SH_WR   = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  entry_t             new_entry;
  entry_t             taken;
  logic [STAT_W-1:0]  result_status;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t             rd_entry;

  logic               cmd_fire;
  logic               last_shift;
  logic               rsp_free;

  assign rd_entry   = entry_t'(ram_rdata);
  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign last_shift = (CNT_W'(idx) + CNT_W'(1)) >= count;
  assign rsp_free   = !rsp.valid || rsp.ready;

  // entry memory
  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // memory access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd_entry;
    ram_raddr = idx;
    case (state)
      S_INS_RD: begin
        ram_raddr = idx - IDX_W'(1);
      end
      S_INS_CMP: begin
        ram_we = (rd_entry.prio > new_entry.prio);
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = new_entry;
      end
      S_SH_RD: begin
        ram_raddr = idx + IDX_W'(1);
      end
      S_SH_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            new_entry.value <= cmd.item_value;
            new_entry.prio  <= cmd.item_priority;
            taken           <= '0;
            result_status   <= ST_DONE;
            state           <= S_OUT;
            case (cmd.kind)
              KIND_INSERT: begin
                if (count == CNT_W'(DEPTH)) begin
                  result_status <= ST_FULL;
                end else begin
                  idx   <= IDX_W'(count);
                  state <= S_INS_RD;
                end
              end
              KIND_REMOVE: begin
                if (count == '0) begin
                  result_status <= ST_EMPTY;
                end else begin
                  idx   <= '0;
                  state <= S_DEL_RD;
                end
              end
              KIND_DELETE: begin
                if (count == '0) begin
                  result_status <= ST_EMPTY;
                end else if (cmd.position == '0 ||
                             OCC_W'(cmd.position) > OCC_W'(count)) begin
                  result_status <= ST_NOPOS;
                end else begin
                  idx   <= IDX_W'(cmd.position - POS_W'(1));
                  state <= S_DEL_RD;
                end
              end
              default: begin
                result_status <= ST_DONE;
              end
            endcase
          end
        end
        // insert: walk down from the tail, moving higher priorities up
        S_INS_RD: begin
          if (idx == '0) begin
            state <= S_INS_PUT;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_entry.prio > new_entry.prio) begin
            idx   <= idx - IDX_W'(1);
            state <= S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_OUT;
        end
        // remove and delete: read the taken entry, then close the gap
        S_DEL_RD: begin
          state <= S_DEL_CAP;
        end
        S_DEL_CAP: begin
          taken <= rd_entry;
          state <= S_SH_RD;
        end
        S_SH_RD: begin
          if (last_shift) begin
            count <= count - CNT_W'(1);
            state <= S_OUT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx   <= idx + IDX_W'(1);
          state <= S_SH_RD;
        end
        S_OUT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_OUT && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_OUT && rsp_free) begin
      rsp.status         <= result_status;
      rsp.taken_value    <= taken.value;
      rsp.taken_priority <= taken.prio;
      rsp.occupancy      <= OCC_W'(count);
    end
  end

endmodule

FILE: hdl/spq_checker.sv
// port-level checks of the sorted priority queue and their binding
module spq_checker import spq_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [STAT_W-1:0]         rsp_status,
  input logic signed [VALUE_W-1:0] rsp_taken_value,
  input logic signed [PRIO_W-1:0]  rsp_taken_priority,
  input logic [OCC_W-1:0]          rsp_occupancy
);

  // a taken command word keeps the block busy in the next cycle
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command word taken while a command is still worked");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_taken_value) && $stable(rsp_taken_priority) &&
      $stable(rsp_occupancy))
    else $error("result word changed while stalled");

  // occupancy stays within the queue size
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond queue size");

  // nothing taken unless the command completed
  a_taken_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DONE |->
      rsp_taken_value == '0 && rsp_taken_priority == '0)
    else $error("entry reported taken on a refused command");

  // full and empty status agree with occupancy
  a_status_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status != ST_FULL || rsp_occupancy == OCC_W'(DEPTH)) &&
      (rsp_status != ST_EMPTY || rsp_occupancy == '0))
    else $error("full or empty status disagrees with occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_taken_value    (rsp.taken_value),
  .rsp_taken_priority (rsp.taken_priority),
  .rsp_occupancy      (rsp.occupancy)
);

FILE: bench/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// self-checking testbench of the sorted priority queue with its own queue predictor
module tb_sorted_priority_queue;
  import spq_pkg::*;

  // the kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;
  localparam int REPORT_LIMIT   = 10;

  // one command word as planned and as accepted
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic [POS_W-1:0]          pos;
    bit                        wait_idle;
  } queue_cmd_t;

  // one result word
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic [OCC_W-1:0]          occ;
  } queue_result_t;

  logic clk;
  logic rst;

  spq_in_if  cmd_if ();
  spq_out_if rsp_if ();

  sorted_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // predicted contents of the queue, head first
  entry_t held [DEPTH];
  int     held_count;

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  int            planned_count;

  bit cmd_taken;
  int gap_left;
  int burst_left;
  int stall_mode;
  int stall_phase_left;
  logic [15:0] stall_pattern;

  int fail_count;
  int idle_cycles;
  int kind_seen [4];
  int status_seen [4];
  int peak_occ;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset and known input values from time zero
  initial begin
    rst                  = 1'b1;
    cmd_if.valid         = 1'b0;
    cmd_if.kind          = KIND_INSERT;
    cmd_if.item_value    = '0;
    cmd_if.item_priority = '0;
    cmd_if.position      = '0;
    rsp_if.ready         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // queue predictor: applies one accepted command, returns its result word
  function automatic queue_result_t apply_cmd(input queue_cmd_t c);
    queue_result_t r;
    int slot;
    int take_idx;
    int i;
    r.status = ST_DONE;
    r.value  = '0;
    r.prio   = '0;
    take_idx = -1;
    case (c.kind)
      KIND_INSERT: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or lower priority
          slot = 0;
          while (slot < held_count && $signed(held[slot].prio) <= $signed(c.prio))
            slot++;
          for (i = held_count; i > slot; i--)
            held[i] = held[i-1];
          held[slot].value = c.value;
          held[slot].prio  = c.prio;
          held_count++;
        end
      end
      KIND_REMOVE: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else take_idx = 0;
      end
      KIND_DELETE: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else if (c.pos == 0 || c.pos > held_count) r.status = ST_NOPOS;
        else take_idx = c.pos - 1;
      end
      default: ;
    endcase
    // take out one entry and close the gap
    if (take_idx >= 0) begin
      r.value = held[take_idx].value;
      r.prio  = held[take_idx].prio;
      for (i = take_idx; i + 1 < held_count; i++)
        held[i] = held[i+1];
      held_count--;
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  // queues one command and tracks the fill level it leads to
  task automatic add_cmd(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value,
                         input logic signed [PRIO_W-1:0] prio, input logic [POS_W-1:0] pos,
                         input bit wait_idle);
    queue_cmd_t c;
    c.kind      = kind;
    c.value     = value;
    c.prio      = prio;
    c.pos       = pos;
    c.wait_idle = wait_idle;
    pending_cmds.push_back(c);
    case (kind)
      KIND_INSERT: if (planned_count < DEPTH) planned_count++;
      KIND_REMOVE: if (planned_count > 0) planned_count--;
      KIND_DELETE: if (planned_count > 0 && pos != 0 && pos <= planned_count) planned_count--;
      default: ;
    endcase
  endtask

  // stimulus, then end of run
  initial begin : stimulus
    int i;
    int real_items;
    int mode;
    int mode_left;
    int insert_pct;
    int r;
    int p;
    bit wait_first;
    logic [KIND_W-1:0]         kind;
    logic signed [PRIO_W-1:0]  prio;
    logic [POS_W-1:0]          pos;

    // empty queue cases
    add_cmd(KIND_REMOVE, 0, 0, 0, 0);
    add_cmd(KIND_DELETE, 0, 0, 0, 0);
    add_cmd(KIND_DELETE, 0, 0, 8'd255, 0);
    add_cmd(KIND_UNUSED, -1, -1, 8'd255, 0);
    // fill with extremes and ties
    add_cmd(KIND_INSERT, 32'sh7fffffff, 16'sh7fff, 0, 0);
    add_cmd(KIND_INSERT, 32'sh80000000, 16'sh8000, 0, 0);
    add_cmd(KIND_INSERT, 0, 0, 0, 0);
    add_cmd(KIND_INSERT, -1, 0, 0, 0);
    add_cmd(KIND_INSERT, 1, -1, 0, 0);
    add_cmd(KIND_INSERT, 2, -1, 0, 0);
    add_cmd(KIND_INSERT, 3, 16'sh7fff, 0, 0);
    add_cmd(KIND_INSERT, 4, 16'sh8000, 0, 0);
    for (i = 0; i < 8; i++)
      add_cmd(KIND_INSERT, $urandom, PRIO_W'((i % 3) - 1), 0, 0);
    // full queue, bad positions, tail and head deletes
    add_cmd(KIND_INSERT, 32'sh5a5a5a5a, 0, 0, 0);
    add_cmd(KIND_DELETE, 0, 0, 0, 0);
    add_cmd(KIND_DELETE, 0, 0, POS_W'(DEPTH + 1), 0);
    add_cmd(KIND_DELETE, 0, 0, POS_W'(DEPTH), 0);
    add_cmd(KIND_DELETE, 0, 0, 1, 0);
    add_cmd(KIND_UNUSED, 0, 0, 0, 0);
    add_cmd(KIND_REMOVE, 0, 0, 0, 0);

    // random phases leaning to filling, draining or mixed traffic
    real_items = 0;
    mode_left  = 0;
    mode       = 0;
    wait_first = 1'b0;
    while (real_items < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        mode       = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 60);
        wait_first = 1'b1;
      end
      mode_left--;
      insert_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      r = $urandom_range(0, 99);
      if (r < 3) kind = KIND_UNUSED;
      else if (r < 3 + insert_pct) kind = KIND_INSERT;
      else if (r % 2) kind = KIND_REMOVE;
      else kind = KIND_DELETE;
      // mostly a few close priorities so ties are common
      p = $urandom_range(0, 9);
      if (p < 6) prio = PRIO_W'(int'($urandom_range(0, 6)) - 3);
      else if (p < 9) prio = PRIO_W'($urandom);
      else prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      // mostly valid positions, the rest zero, one past the end or random
      p = $urandom_range(0, 9);
      if (planned_count > 0 && p < 7) pos = POS_W'($urandom_range(1, planned_count));
      else if (p < 8) pos = POS_W'(planned_count + 1);
      else if (p == 8) pos = 0;
      else pos = POS_W'($urandom_range(0, 255));
      add_cmd(kind, $urandom, prio, pos, wait_first);
      wait_first = 1'b0;
      if (kind != KIND_UNUSED) real_items++;
    end

    // wait until all words are sent and answered, then a short tail
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d deletes, %0d ignored words",
             kind_seen[KIND_INSERT], kind_seen[KIND_REMOVE], kind_seen[KIND_DELETE],
             kind_seen[KIND_UNUSED]);
    $display("status done %0d, empty %0d, no position %0d, full %0d, peak occupancy %0d",
             status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_NOPOS],
             status_seen[ST_FULL], peak_occ);
    if (fail_count == 0) begin
      $display("tb_sorted_priority_queue passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb_sorted_priority_queue failed");
    end
    $finish;
  end

  // command driver: bursts with random gaps, pauses where a word asks for an idle queue
  always @(negedge clk) begin : driver
    queue_cmd_t c;
    if (rst) begin
      cmd_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else if (cmd_if.valid && !cmd_taken) begin
      // hold the word until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      cmd_if.valid <= 1'b0;
    end else if (pending_cmds.size() == 0 ||
                 (pending_cmds[0].wait_idle && expected_results.size() != 0)) begin
      cmd_if.valid <= 1'b0;
    end else begin
      c = pending_cmds.pop_front();
      cmd_if.valid         <= 1'b1;
      cmd_if.kind          <= c.kind;
      cmd_if.item_value    <= c.value;
      cmd_if.item_priority <= c.prio;
      cmd_if.position      <= c.pos;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // result receiver: phases of no stall, random stall and a rotating stall pattern
  always @(negedge clk) begin : receiver
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_phase_left = 0;
      stall_mode       = 0;
      stall_pattern    = 16'hffff;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(0, 2);
        stall_phase_left = $urandom_range(50, 300);
        stall_pattern    = 16'($urandom & $urandom) | 16'h0001;
      end
      stall_phase_left--;
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          rsp_if.ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  // monitor: predicts on each accepted command, checks each accepted result
  always @(posedge clk) begin : monitor
    queue_cmd_t    c;
    queue_result_t want;
    queue_result_t got;
    if (rst) begin
      cmd_taken   = 1'b0;
      idle_cycles = 0;
    end else begin
      cmd_taken = cmd_if.valid && cmd_if.ready;
      if (cmd_taken) begin
        c.kind      = cmd_if.kind;
        c.value     = cmd_if.item_value;
        c.prio      = cmd_if.item_priority;
        c.pos       = cmd_if.position;
        c.wait_idle = 1'b0;
        want = apply_cmd(c);
        expected_results.push_back(want);
        kind_seen[c.kind]++;
        status_seen[want.status]++;
        if (want.occ > peak_occ) peak_occ = want.occ;
      end

      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.value  = rsp_if.taken_value;
        got.prio   = rsp_if.taken_priority;
        got.occ    = rsp_if.occupancy;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%t: result word with none expected: status %0d value %0d prio %0d occ %0d",
                     $realtime, got.status, got.value, got.prio, got.occ);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.prio !== want.prio || got.occ !== want.occ) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%t: mismatch: expected status %0d value %0d prio %0d occ %0d, got status %0d value %0d prio %0d occ %0d",
                       $realtime, want.status, want.value, want.prio, want.occ,
                       got.status, got.value, got.prio, got.occ);
          end
        end
      end

      // watchdog on cycles without any handshake
      if (cmd_taken || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("no handshake for %0d cycles, %0d results outstanding",
                   idle_cycles, expected_results.size());
          $display("tb_sorted_priority_queue failed");
          $finish;
        end
      end
    end
  end

endmodule

FILE: files.f
hdl/spq_pkg.sv
hdl/spq_in_if.sv
hdl/spq_out_if.sv
hdl/spq_ram.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
bench/tb_sorted_priority_queue.sv
